>>> rtl/gsu_pkg.sv
// Shared types and constants for the grid snap unit.
package gsu_pkg;

	// Default coordinate width (Q24.8 by default, fraction bits do not touch the math)
	localparam int COORD_WIDTH = 32;
	// Quotient / multiplier bits retired per divide-multiply stage
	localparam int STEP_BITS = 2;
	localparam int OP_WIDTH = 3;
	localparam int CFG_INDEX_WIDTH = 2;

	typedef enum logic [OP_WIDTH-1:0] {
		OP_NEAREST  = 3'd0,
		OP_DOWN     = 3'd1,
		OP_UP       = 3'd2,
		OP_INDEX    = 3'd3,
		OP_POSITION = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_ZERO = 2'd2
	} status_t;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_X_PITCH  = 2'd0,
		REG_X_OFFSET = 2'd1,
		REG_Y_PITCH  = 2'd2,
		REG_Y_OFFSET = 2'd3
	} cfg_reg_t;

	// Per-item control that rides along the pipeline
	typedef struct packed {
		op_t  op;
		logic pzero;  // selected pitch is zero
		logic dneg;   // coord - offset is negative
		logic ineg;   // grid index is negative
	} ctl_t;

endpackage

>>> rtl/gsu_in_if.sv
// Input item channel: valid/ready handshake with coordinate payload.
interface gsu_in_if #(
	parameter int COORD_WIDTH = gsu_pkg::COORD_WIDTH
);
	logic                              valid;
	logic                              ready;
	logic [gsu_pkg::OP_WIDTH-1:0]      operation;
	logic                              axis;
	logic signed [COORD_WIDTH-1:0]     coord;
	logic signed [COORD_WIDTH-1:0]     grid_index;

	modport source (output valid, operation, axis, coord, grid_index, input ready);
	modport sink (input valid, operation, axis, coord, grid_index, output ready);
endinterface

>>> rtl/gsu_out_if.sv
// Result channel: valid/ready handshake with snapped value and status.
interface gsu_out_if #(
	parameter int COORD_WIDTH = gsu_pkg::COORD_WIDTH
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] value;
	gsu_pkg::status_t              status;

	modport source (output valid, value, status, input ready);
	modport sink (input valid, value, status, output ready);
endinterface

>>> rtl/grid_snap_unit.sv
// Grid snap unit top level: front end, divide/multiply stage chain, back end.
//
//  channel  | role   | handshake      | payload
//  ---------+--------+----------------+-------------------------------------------
//  item     | sink   | valid / ready  | operation, axis, coord, grid_index
//  result   | source | valid / ready  | value, status
//  cfg      | write  | cfg_write      | cfg_index, cfg_data (pitch / offset regs)
//
// One transfer per cycle sustained while the result side holds ready. Depth is 2 front
// stages + NST divide stages + 2 back stages + the output register; NST = (COORD_WIDTH+2)/2
// with 2 quotient bits per stage. The restoring divider sets the depth.
// Reset clears the valid bits and the four config registers; payload regs are not reset.
// Every stage moves when it is empty or its successor moves, so bubbles close up and the
// input keeps taking transfers while a result waits at the output register, until the chain is full.
module grid_snap_unit #(
	parameter int COORD_WIDTH = gsu_pkg::COORD_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	gsu_in_if.sink                              item,
	gsu_out_if.source                           result,
	input  logic                                cfg_write,
	input  logic [gsu_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [COORD_WIDTH-1:0]              cfg_data
);
	localparam int W   = COORD_WIDTH;
	localparam int PW  = W - 1;
	localparam int NST = (W + gsu_pkg::STEP_BITS) / gsu_pkg::STEP_BITS;
	localparam int QW  = NST * gsu_pkg::STEP_BITS;
	localparam int AW  = 2 * W - 1;
	localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};

	// Stage chain taps: index 0 is the front-end output, index NST feeds the back end
	logic          st_valid [0:NST];
	logic          st_ready [0:NST];
	gsu_pkg::ctl_t st_ctl   [0:NST];
	logic [PW-1:0] st_pitch [0:NST];
	logic [W-1:0]  st_off   [0:NST];
	logic [W-1:0]  st_coord [0:NST];
	logic [PW-1:0] st_rem   [0:NST];
	logic [QW-1:0] st_dq    [0:NST];
	logic [AW-1:0] st_acc   [0:NST];
	logic [QW-1:0] st_mlt   [0:NST];

	logic [W:0]    f_dmag;
	logic [W-1:0]  f_imag;

	// Front end: config regs, axis select, coord - offset, magnitudes
	gsu_front #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.dn_valid  (st_valid[0]),
		.dn_ready  (st_ready[0]),
		.dn_ctl    (st_ctl[0]),
		.dn_pitch  (st_pitch[0]),
		.dn_offset (st_off[0]),
		.dn_coord  (st_coord[0]),
		.dn_dmag   (f_dmag),
		.dn_imag   (f_imag)
	);

	// Divider starts with a zero partial remainder; multiplier with a zero accumulator
	assign st_rem[0] = '0;
	assign st_dq[0]  = QW'(f_dmag);
	assign st_acc[0] = '0;
	assign st_mlt[0] = QW'(f_imag);

	// Divide and multiply run side by side, STEP_BITS bits per stage
	for (genvar g = 0; g < NST; g++) begin : g_step
		gsu_step #(
			.COORD_WIDTH (COORD_WIDTH)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.up_valid  (st_valid[g]),
			.up_ready  (st_ready[g]),
			.up_ctl    (st_ctl[g]),
			.up_pitch  (st_pitch[g]),
			.up_offset (st_off[g]),
			.up_coord  (st_coord[g]),
			.up_rem    (st_rem[g]),
			.up_dq     (st_dq[g]),
			.up_acc    (st_acc[g]),
			.up_mlt    (st_mlt[g]),
			.dn_valid  (st_valid[g+1]),
			.dn_ready  (st_ready[g+1]),
			.dn_ctl    (st_ctl[g+1]),
			.dn_pitch  (st_pitch[g+1]),
			.dn_offset (st_off[g+1]),
			.dn_coord  (st_coord[g+1]),
			.dn_rem    (st_rem[g+1]),
			.dn_dq     (st_dq[g+1]),
			.dn_acc    (st_acc[g+1]),
			.dn_mlt    (st_mlt[g+1])
		);
	end

	// Back end: floor fixup, candidates, select, saturate, output register.
	// The spent multiplier bits of the last stage are not needed there.
	gsu_back #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (st_valid[NST]),
		.up_ready  (st_ready[NST]),
		.up_ctl    (st_ctl[NST]),
		.up_pitch  (st_pitch[NST]),
		.up_offset (st_off[NST]),
		.up_coord  (st_coord[NST]),
		.up_rem    (st_rem[NST]),
		.up_dq     (st_dq[NST]),
		.up_acc    (st_acc[NST]),
		.result    (result)
	);

	// Input back-pressure can only come from a full chain behind a stalled output
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> (result.valid && !result.ready))
		else $error("input stalled while the output is not blocked");

	// A saturated result sits exactly on a range bound
	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.status == gsu_pkg::ST_SAT)
		|-> (result.value == SAT_MIN || result.value == SAT_MAX))
		else $error("saturated value is not a range bound");

	// The last divide stage holds its item while the back end is full
	a_chain_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(st_valid[NST] && !st_ready[NST]) |=> st_valid[NST])
		else $error("divide chain dropped an item under stall");

endmodule

>>> rtl/gsu_front.sv
// Config registers, axis select, coord-offset difference and magnitudes.
module gsu_front #(
	parameter int COORD_WIDTH = gsu_pkg::COORD_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	gsu_in_if.sink                              item,
	input  logic                                cfg_write,
	input  logic [gsu_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [COORD_WIDTH-1:0]              cfg_data,
	output logic                                dn_valid,
	input  logic                                dn_ready,
	output gsu_pkg::ctl_t                       dn_ctl,
	output logic [COORD_WIDTH-2:0]              dn_pitch,
	output logic [COORD_WIDTH-1:0]              dn_offset,
	output logic [COORD_WIDTH-1:0]              dn_coord,
	output logic [COORD_WIDTH:0]                dn_dmag,
	output logic [COORD_WIDTH-1:0]              dn_imag
);
	localparam int W  = COORD_WIDTH;
	localparam int PW = W - 1;

	logic [PW-1:0] x_pitch_q, y_pitch_q;
	logic [W-1:0]  x_offset_q, y_offset_q;

	logic [PW-1:0] sel_pitch;
	logic [W-1:0]  sel_offset;
	logic [W:0]    diff;

	logic            v_s1, rdy_s1;
	gsu_pkg::op_t    op_s1;
	logic            pzero_s1;
	logic [PW-1:0]   pitch_s1;
	logic [W-1:0]    off_s1, c_s1, idx_s1;
	logic [W:0]      d_s1;

	logic            v_s2, rdy_s2;
	gsu_pkg::ctl_t   ctl_s2;
	logic [PW-1:0]   pitch_s2;
	logic [W-1:0]    off_s2, c_s2, imag_s2;
	logic [W:0]      dmag_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_pitch_q  <= '0;
			x_offset_q <= '0;
			y_pitch_q  <= '0;
			y_offset_q <= '0;
		end else if (cfg_write) begin
			case (gsu_pkg::cfg_reg_t'(cfg_index))
				gsu_pkg::REG_X_PITCH:  x_pitch_q  <= cfg_data[PW-1:0];
				gsu_pkg::REG_X_OFFSET: x_offset_q <= cfg_data;
				gsu_pkg::REG_Y_PITCH:  y_pitch_q  <= cfg_data[PW-1:0];
				gsu_pkg::REG_Y_OFFSET: y_offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign sel_pitch  = item.axis ? y_pitch_q : x_pitch_q;
	assign sel_offset = item.axis ? y_offset_q : x_offset_q;
	assign diff       = {item.coord[W-1], item.coord} - {sel_offset[W-1], sel_offset};

	assign rdy_s1     = !v_s1 || rdy_s2;
	assign rdy_s2     = !v_s2 || dn_ready;
	assign item.ready = rdy_s1;

	// stage 1: select axis, subtract offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && item.valid) begin
			op_s1    <= gsu_pkg::op_t'(item.operation);
			pzero_s1 <= (sel_pitch == '0);
			pitch_s1 <= sel_pitch;
			off_s1   <= sel_offset;
			c_s1     <= item.coord;
			idx_s1   <= item.grid_index;
			d_s1     <= diff;
		end
	end

	// stage 2: magnitudes for the unsigned divide and multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			ctl_s2.op    <= op_s1;
			ctl_s2.pzero <= pzero_s1;
			ctl_s2.dneg  <= d_s1[W];
			ctl_s2.ineg  <= idx_s1[W-1];
			pitch_s2     <= pitch_s1;
			off_s2       <= off_s1;
			c_s2         <= c_s1;
			dmag_s2      <= d_s1[W] ? (~d_s1 + (W+1)'(1)) : d_s1;
			imag_s2      <= idx_s1[W-1] ? (~idx_s1 + W'(1)) : idx_s1;
		end
	end

	assign dn_valid  = v_s2;
	assign dn_ctl    = ctl_s2;
	assign dn_pitch  = pitch_s2;
	assign dn_offset = off_s2;
	assign dn_coord  = c_s2;
	assign dn_dmag   = dmag_s2;
	assign dn_imag   = imag_s2;

endmodule

>>> rtl/gsu_step.sv
// One divide/multiply pipeline stage: restoring divide and shift-add multiply.
module gsu_step #(
	parameter int COORD_WIDTH = gsu_pkg::COORD_WIDTH
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            up_valid,
	output logic                                            up_ready,
	input  gsu_pkg::ctl_t                                   up_ctl,
	input  logic [COORD_WIDTH-2:0]                          up_pitch,
	input  logic [COORD_WIDTH-1:0]                          up_offset,
	input  logic [COORD_WIDTH-1:0]                          up_coord,
	input  logic [COORD_WIDTH-2:0]                          up_rem,
	input  logic [((COORD_WIDTH+gsu_pkg::STEP_BITS)/gsu_pkg::STEP_BITS)
	              *gsu_pkg::STEP_BITS-1:0]                  up_dq,
	input  logic [2*COORD_WIDTH-2:0]                        up_acc,
	input  logic [((COORD_WIDTH+gsu_pkg::STEP_BITS)/gsu_pkg::STEP_BITS)
	              *gsu_pkg::STEP_BITS-1:0]                  up_mlt,
	output logic                                            dn_valid,
	input  logic                                            dn_ready,
	output gsu_pkg::ctl_t                                   dn_ctl,
	output logic [COORD_WIDTH-2:0]                          dn_pitch,
	output logic [COORD_WIDTH-1:0]                          dn_offset,
	output logic [COORD_WIDTH-1:0]                          dn_coord,
	output logic [COORD_WIDTH-2:0]                          dn_rem,
	output logic [((COORD_WIDTH+gsu_pkg::STEP_BITS)/gsu_pkg::STEP_BITS)
	              *gsu_pkg::STEP_BITS-1:0]                  dn_dq,
	output logic [2*COORD_WIDTH-2:0]                        dn_acc,
	output logic [((COORD_WIDTH+gsu_pkg::STEP_BITS)/gsu_pkg::STEP_BITS)
	              *gsu_pkg::STEP_BITS-1:0]                  dn_mlt
);
	localparam int W   = COORD_WIDTH;
	localparam int PW  = W - 1;
	localparam int NST = (W + gsu_pkg::STEP_BITS) / gsu_pkg::STEP_BITS;
	localparam int QW  = NST * gsu_pkg::STEP_BITS;
	localparam int AW  = 2 * W - 1;

	logic [W-1:0]  trial;
	logic          take;
	logic [PW-1:0] rem_n;
	logic [QW-1:0] dq_n, mlt_n;
	logic [AW-1:0] acc_n;

	logic          v_s1, rdy_s1;
	gsu_pkg::ctl_t ctl_s1;
	logic [PW-1:0] pitch_s1, rem_s1;
	logic [W-1:0]  off_s1, c_s1;
	logic [QW-1:0] dq_s1, mlt_s1;
	logic [AW-1:0] acc_s1;

	// dq shifts dividend bits out at the top and quotient bits in at the bottom
	always_comb begin
		trial = '0;
		take  = 1'b0;
		rem_n = up_rem;
		dq_n  = up_dq;
		acc_n = up_acc;
		mlt_n = up_mlt;
		for (int k = 0; k < gsu_pkg::STEP_BITS; k++) begin
			trial = {rem_n, dq_n[QW-1]};
			take  = (trial >= {1'b0, up_pitch});
			rem_n = take ? PW'(trial - {1'b0, up_pitch}) : trial[PW-1:0];
			dq_n  = {dq_n[QW-2:0], take};
			acc_n = {acc_n[AW-2:0], 1'b0} + (mlt_n[QW-1] ? AW'(up_pitch) : AW'(0));
			mlt_n = {mlt_n[QW-2:0], 1'b0};
		end
	end

	assign rdy_s1   = !v_s1 || dn_ready;
	assign up_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			ctl_s1   <= up_ctl;
			pitch_s1 <= up_pitch;
			off_s1   <= up_offset;
			c_s1     <= up_coord;
			rem_s1   <= rem_n;
			dq_s1    <= dq_n;
			acc_s1   <= acc_n;
			mlt_s1   <= mlt_n;
		end
	end

	assign dn_valid  = v_s1;
	assign dn_ctl    = ctl_s1;
	assign dn_pitch  = pitch_s1;
	assign dn_offset = off_s1;
	assign dn_coord  = c_s1;
	assign dn_rem    = rem_s1;
	assign dn_dq     = dq_s1;
	assign dn_acc    = acc_s1;
	assign dn_mlt    = mlt_s1;

endmodule

>>> rtl/gsu_back.sv
// Floor fixup, snap candidates, operation select, saturation and output register.
module gsu_back #(
	parameter int COORD_WIDTH = gsu_pkg::COORD_WIDTH
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            up_valid,
	output logic                                            up_ready,
	input  gsu_pkg::ctl_t                                   up_ctl,
	input  logic [COORD_WIDTH-2:0]                          up_pitch,
	input  logic [COORD_WIDTH-1:0]                          up_offset,
	input  logic [COORD_WIDTH-1:0]                          up_coord,
	input  logic [COORD_WIDTH-2:0]                          up_rem,
	input  logic [((COORD_WIDTH+gsu_pkg::STEP_BITS)/gsu_pkg::STEP_BITS)
	              *gsu_pkg::STEP_BITS-1:0]                  up_dq,
	input  logic [2*COORD_WIDTH-2:0]                        up_acc,
	gsu_out_if.source                                       result
);
	localparam int W  = COORD_WIDTH;
	localparam int PW = W - 1;
	localparam int RW = W + 2;
	localparam int AW = 2 * W - 1;
	localparam logic [AW-1:0] PROD_LIM = {{(AW-W-1){1'b0}}, 1'b1, {W{1'b0}}};
	localparam logic [W-1:0]  SAT_MIN  = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0]  SAT_MAX  = {1'b0, {(W-1){1'b1}}};

	// stage 1 inputs
	logic [W:0]    qa;
	logic [RW-1:0] qx;
	logic          ra_nz;

	logic          v_s1, rdy_s1;
	gsu_pkg::ctl_t ctl_s1;
	logic [PW-1:0] pitch_s1, r_s1;
	logic [W-1:0]  off_s1, c_s1;
	logic [RW-1:0] q_s1, sp_s1;
	logic          big_s1;

	logic          v_s2, rdy_s2;
	gsu_pkg::ctl_t ctl_s2;
	logic [W-1:0]  off_s2, c_s2;
	logic [RW-1:0] q_s2, pos_s2, down_s2;
	logic [PW-1:0] pmr_s2;
	logic          rnz_s2, near_up_s2, big_s2;

	logic [RW-1:0] cx_s2, up_val, raw;
	logic          fits;
	logic [W-1:0]  value_n;
	gsu_pkg::status_t status_n;

	logic             out_v_q, rdy_o;
	logic [W-1:0]     value_q;
	gsu_pkg::status_t status_q;

	assign rdy_o    = !out_v_q || result.ready;
	assign rdy_s2   = !v_s2 || rdy_o;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	// stage 1: turn the magnitude quotient into floor quotient and remainder in [0, p)
	assign qa    = up_dq[W:0];
	assign qx    = RW'(qa);
	assign ra_nz = |up_rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			ctl_s1   <= up_ctl;
			pitch_s1 <= up_pitch;
			off_s1   <= up_offset;
			c_s1     <= up_coord;
			if (up_ctl.dneg) begin
				q_s1 <= ra_nz ? ~qx : (~qx + RW'(1));
				r_s1 <= ra_nz ? (up_pitch - up_rem) : up_rem;
			end else begin
				q_s1 <= qx;
				r_s1 <= up_rem;
			end
			big_s1 <= (up_acc > PROD_LIM);
			sp_s1  <= up_ctl.ineg ? (~up_acc[RW-1:0] + RW'(1)) : up_acc[RW-1:0];
		end
	end

	// stage 2: down candidate, p - r, tie test and position sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			ctl_s2     <= ctl_s1;
			off_s2     <= off_s1;
			c_s2       <= c_s1;
			q_s2       <= q_s1;
			big_s2     <= big_s1;
			down_s2    <= {{2{c_s1[W-1]}}, c_s1} - RW'(r_s1);
			pmr_s2     <= pitch_s1 - r_s1;
			rnz_s2     <= |r_s1;
			// p - r < r  <=>  2r > p
			near_up_s2 <= ({r_s1, 1'b0} > {1'b0, pitch_s1});
			pos_s2     <= sp_s1 + {{2{off_s1[W-1]}}, off_s1};
		end
	end

	// stage 3: pick by operation, clamp to the coordinate range
	assign cx_s2 = {{2{c_s2[W-1]}}, c_s2};

	always_comb begin
		up_val = rnz_s2 ? (cx_s2 + RW'(pmr_s2)) : cx_s2;
		case (ctl_s2.op)
			gsu_pkg::OP_NEAREST:  raw = near_up_s2 ? up_val : down_s2;
			gsu_pkg::OP_DOWN:     raw = down_s2;
			gsu_pkg::OP_UP:       raw = up_val;
			gsu_pkg::OP_INDEX:    raw = q_s2;
			gsu_pkg::OP_POSITION: raw = pos_s2;
			default:              raw = cx_s2;
		endcase
		fits     = (&raw[RW-1:W-1]) || !(|raw[RW-1:W-1]);
		value_n  = fits ? raw[W-1:0] : (raw[RW-1] ? SAT_MIN : SAT_MAX);
		status_n = fits ? gsu_pkg::ST_OK : gsu_pkg::ST_SAT;
		if (ctl_s2.op inside {gsu_pkg::OP_NEAREST, gsu_pkg::OP_DOWN, gsu_pkg::OP_UP,
		                      gsu_pkg::OP_INDEX}) begin
			if (ctl_s2.pzero) begin
				value_n  = (ctl_s2.op == gsu_pkg::OP_INDEX) ? '0 : c_s2;
				status_n = gsu_pkg::ST_ZERO;
			end
		end else if (ctl_s2.op == gsu_pkg::OP_POSITION) begin
			if (ctl_s2.pzero) begin
				value_n  = off_s2;
				status_n = gsu_pkg::ST_ZERO;
			end else if (big_s2) begin
				value_n  = ctl_s2.ineg ? SAT_MIN : SAT_MAX;
				status_n = gsu_pkg::ST_SAT;
			end
		end else begin
			value_n  = c_s2;
			status_n = gsu_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (rdy_o) begin
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o && v_s2) begin
			value_q  <= value_n;
			status_q <= status_n;
		end
	end

	assign result.valid  = out_v_q;
	assign result.value  = value_q;
	assign result.status = status_q;

endmodule

>>> test/grid_snap_unit_tb.sv
// Self-checking testbench for the grid snap unit: directed, random and back-pressure runs.
`timescale 1ns / 100ps

module grid_snap_unit_tb;

	localparam int CW = 32;
	localparam int CYCLE_LIMIT = 400000;
	// pipeline depth is 22; leave some slack after the last result
	localparam int SETTLE_CYCLES = 40;
	localparam longint COORD_MAX = 64'sd2147483647;
	localparam longint COORD_MIN = -64'sd2147483648;
	localparam longint COORD_SPAN = 64'sd4294967296;

	typedef struct packed {
		logic [CW-1:0]    value;
		gsu_pkg::status_t status;
	} snap_result_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_write;
	gsu_pkg::cfg_reg_t cfg_index;
	logic [CW-1:0]     cfg_data;

	gsu_in_if  item_ch ();
	gsu_out_if result_ch ();

	grid_snap_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the grid registers, as the block should hold them
	longint grid_x_pitch;
	longint grid_x_offset;
	longint grid_y_pitch;
	longint grid_y_offset;

	// Snapped results still owed by the block, oldest first
	snap_result_t snap_expect_q[$];

	int mismatch_count;
	int cycle_count;
	int send_idle_pct;   // chance per cycle that the sender holds back
	int stall_pct;       // chance per cycle that the receiver drops ready
	int hold_cycles;     // long receiver hold-off, consumed by the receiver process

	// ------------------------------------------------------------------
	// Clock, reset and watchdog
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic longint sat_coord(longint v, inout gsu_pkg::status_t st);
		if (v > COORD_MAX) begin
			st = gsu_pkg::ST_SAT;
			return COORD_MAX;
		end
		if (v < COORD_MIN) begin
			st = gsu_pkg::ST_SAT;
			return COORD_MIN;
		end
		return v;
	endfunction

	function automatic snap_result_t predict_snap(logic [2:0] op, logic ax,
			logic [CW-1:0] coord, logic [CW-1:0] gidx);
		longint c, idx, p, off, val, d, q, r, mag;
		snap_result_t res;
		c   = longint'($signed(coord));
		idx = longint'($signed(gidx));
		p   = ax ? grid_y_pitch : grid_x_pitch;
		off = ax ? grid_y_offset : grid_x_offset;
		val = c;
		res.status = gsu_pkg::ST_OK;
		if (op <= gsu_pkg::OP_INDEX) begin
			if (p == 0) begin
				// no grid: coordinate passes, index reads as zero
				val = (op == gsu_pkg::OP_INDEX) ? 0 : c;
				res.status = gsu_pkg::ST_ZERO;
			end else begin
				// floor remainder in [0, pitch)
				d = c - off;
				q = d / p;
				r = d - q * p;
				if (r < 0) begin
					q = q - 1;
					r = r + p;
				end
				case (op)
					gsu_pkg::OP_NEAREST: val = (p - r < r) ? c + (p - r) : c - r;  // tie goes low
					gsu_pkg::OP_DOWN:    val = c - r;
					gsu_pkg::OP_UP:      val = (r != 0) ? c + (p - r) : c;
					default:             val = q;
				endcase
				val = sat_coord(val, res.status);
			end
		end else if (op == gsu_pkg::OP_POSITION) begin
			mag = (idx < 0) ? -idx : idx;
			if (p == 0) begin
				val = off;
				res.status = gsu_pkg::ST_ZERO;
			end else if (mag != 0 && p > COORD_SPAN / mag) begin
				val = (idx < 0) ? COORD_MIN : COORD_MAX;
				res.status = gsu_pkg::ST_SAT;
			end else begin
				val = sat_coord(p * idx + off, res.status);
			end
		end
		// codes above OP_POSITION fall through with the coordinate and ok status
		res.value = val[CW-1:0];
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Result side: ready generation and checking
	// ------------------------------------------------------------------
	// The long hold-off is counted here so the sender keeps pushing meanwhile.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				result_ch.ready <= 1'b0;
				hold_cycles--;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Sampled mid-cycle: the values seen here are the ones the next edge uses.
	initial begin
		snap_result_t exp_res;
		forever begin
			@(negedge clk);
			if (result_ch.valid && result_ch.ready) begin
				if (snap_expect_q.size() == 0) begin
					$display("%0t: unexpected result transfer value=%h status=%0d",
						$time, result_ch.value, result_ch.status);
					mismatch_count++;
				end else begin
					exp_res = snap_expect_q.pop_front();
					if (result_ch.value !== exp_res.value) begin
						$display("%0t: value mismatch expected=%h actual=%h",
							$time, exp_res.value, result_ch.value);
						mismatch_count++;
					end
					if (result_ch.status !== exp_res.status) begin
						$display("%0t: status mismatch expected=%0d actual=%0d",
							$time, exp_res.status, result_ch.status);
						mismatch_count++;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender and configuration helpers (entered and left at a rising edge)
	// ------------------------------------------------------------------
	task automatic send_item(logic [2:0] op, logic ax, logic [CW-1:0] coord,
			logic [CW-1:0] gidx);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.operation  <= op;
		item_ch.axis       <= ax;
		item_ch.coord      <= coord;
		item_ch.grid_index <= gidx;
		do
			@(negedge clk);
		while (!item_ch.ready);
		// the transfer lands on the coming edge
		snap_expect_q.push_back(predict_snap(op, ax, coord, gidx));
		@(posedge clk);
	endtask

	// Stop offering, let every owed result come back, then settle.
	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (snap_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all four grid registers on back-to-back edges; pitch bit 31 is dropped.
	task automatic load_grid(logic [CW-1:0] xp, logic [CW-1:0] xo,
			logic [CW-1:0] yp, logic [CW-1:0] yo);
		cfg_write <= 1'b1;
		cfg_index <= gsu_pkg::REG_X_PITCH;
		cfg_data  <= xp;
		@(posedge clk);
		cfg_index <= gsu_pkg::REG_X_OFFSET;
		cfg_data  <= xo;
		@(posedge clk);
		cfg_index <= gsu_pkg::REG_Y_PITCH;
		cfg_data  <= yp;
		@(posedge clk);
		cfg_index <= gsu_pkg::REG_Y_OFFSET;
		cfg_data  <= yo;
		@(posedge clk);
		cfg_write <= 1'b0;
		grid_x_pitch  = longint'(xp[CW-2:0]);
		grid_x_offset = longint'($signed(xo));
		grid_y_pitch  = longint'(yp[CW-2:0]);
		grid_y_offset = longint'($signed(yo));
	endtask

	// ------------------------------------------------------------------
	// Random content
	// ------------------------------------------------------------------
	function automatic logic [CW-1:0] rand_pitch();
		case ($urandom_range(6))
			0:       return '0;
			1:       return $urandom_range(16, 1);
			2:       return $urandom_range(5000, 1);
			3:       return 32'd1 << $urandom_range(30, 0);
			4:       return $urandom;  // top bit is masked off by the register
			5:       return {1'($urandom_range(1)), 31'h7FFF_FFFF};
			default: return $urandom_range(1 << 20, 1);
		endcase
	endfunction

	function automatic logic [CW-1:0] rand_offset();
		case ($urandom_range(4))
			0:       return '0;
			1:       return $urandom_range(4000) - 2000;
			2:       return 32'h7FFF_FFFF;
			3:       return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [CW-1:0] rand_coord();
		case ($urandom_range(5))
			0:       return 32'h7FFF_FFFF - $urandom_range(300);
			1:       return 32'h8000_0000 + $urandom_range(300);
			2:       return $urandom_range(20000) - 10000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [CW-1:0] rand_index();
		case ($urandom_range(5))
			0:       return $urandom;
			1:       return 32'h7FFF_FFFF - $urandom_range(3);
			2:       return 32'h8000_0000 + $urandom_range(3);
			default: return $urandom_range(2000) - 1000;
		endcase
	endfunction

	function automatic logic [2:0] rand_op();
		// mostly real operations, a few unused codes
		if ($urandom_range(19) == 0)
			return 3'($urandom_range(7, 5));
		return 3'($urandom_range(4));
	endfunction

	task automatic send_random_items(int n);
		for (int i = 0; i < n; i++)
			send_item(rand_op(), 1'($urandom_range(1)), rand_coord(), rand_index());
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Registers still at reset: every axis has pitch zero.
	task automatic test_pitch_zero();
		send_item(gsu_pkg::OP_NEAREST, 1'b0, 32'h7FFF_FFFF, 32'h0);
		send_item(gsu_pkg::OP_DOWN, 1'b1, 32'h8000_0000, 32'h0);
		send_item(gsu_pkg::OP_UP, 1'b0, 32'h0000_0101, 32'hFFFF_FFFF);
		send_item(gsu_pkg::OP_INDEX, 1'b1, 32'h1234_5678, 32'h0);
		send_item(gsu_pkg::OP_POSITION, 1'b0, 32'h0, 32'h7FFF_FFFF);
		send_item(3'd7, 1'b1, 32'hDEAD_BEEF, 32'h8000_0000);
		wait_idle();
	endtask

	// Pitch 1.0 with a quarter offset on X; odd pitch with negative offset on Y.
	task automatic test_basic_grid();
		load_grid(32'd256, 32'd64, 32'd3, -32'sd5);
		send_item(gsu_pkg::OP_NEAREST, 1'b0, 32'd192, 32'h0);   // exact midpoint, goes low
		send_item(gsu_pkg::OP_NEAREST, 1'b0, 32'd193, 32'h0);   // just past midpoint
		send_item(gsu_pkg::OP_DOWN, 1'b0, -32'sd1, 32'h0);      // below offset
		send_item(gsu_pkg::OP_UP, 1'b0, 32'd320, 32'h0);        // already on a line
		send_item(gsu_pkg::OP_UP, 1'b0, 32'd321, 32'h0);
		send_item(gsu_pkg::OP_INDEX, 1'b0, -32'sd1, 32'h0);     // negative floor index
		send_item(gsu_pkg::OP_POSITION, 1'b0, 32'h0, -32'sd3);
		send_item(gsu_pkg::OP_NEAREST, 1'b1, 32'd0, 32'h0);
		send_item(3'd5, 1'b1, 32'd77, 32'd9);
		wait_idle();
	endtask

	// Widest pitch and offsets at the bounds, to push results toward the range bounds and into saturation.
	task automatic test_extremes();
		load_grid(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd1, 32'h8000_0000);
		send_item(gsu_pkg::OP_UP, 1'b0, 32'h8000_0000, 32'h0);
		send_item(gsu_pkg::OP_NEAREST, 1'b0, 32'h7FFF_FFFF, 32'h0);
		send_item(gsu_pkg::OP_DOWN, 1'b0, 32'h8000_0000, 32'h0);
		send_item(gsu_pkg::OP_INDEX, 1'b1, 32'h7FFF_FFFF, 32'h0);   // index past the range
		send_item(gsu_pkg::OP_POSITION, 1'b0, 32'hAAAA_5555, 32'h7FFF_FFFF);
		send_item(gsu_pkg::OP_POSITION, 1'b0, 32'h5555_AAAA, 32'h8000_0000);
		send_item(gsu_pkg::OP_POSITION, 1'b1, 32'h0, 32'h0);
		send_item(gsu_pkg::OP_POSITION, 1'b1, 32'h0, 32'hFFFF_FFFF);
		wait_idle();
	endtask

	// Random grids and items under each idling mix.
	task automatic test_random();
		int idle_mix[4]  = '{0, 66, 0, 35};
		int stall_mix[4] = '{0, 0, 66, 35};
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_mix[ph];
			stall_pct     = stall_mix[ph];
			for (int g = 0; g < 2; g++) begin
				load_grid(rand_pitch(), rand_offset(), rand_pitch(), rand_offset());
				send_random_items(60);
				wait_idle();
			end
		end
		send_idle_pct = 0;
		stall_pct     = 0;
	endtask

	// Receiver goes quiet long enough for the pipeline to fill and block input.
	task automatic test_backpressure();
		load_grid(32'd1000, 32'd17, 32'd256, -32'sd128);
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_cycles   = 120;
		send_random_items(60);
		wait_idle();
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		mismatch_count = 0;
		send_idle_pct  = 0;
		stall_pct      = 0;
		hold_cycles    = 0;
		grid_x_pitch   = 0;
		grid_x_offset  = 0;
		grid_y_pitch   = 0;
		grid_y_offset  = 0;

		arst_n             = 1'b0;
		cfg_write          = 1'b0;
		cfg_index          = gsu_pkg::REG_X_PITCH;
		cfg_data           = '0;
		item_ch.valid      = 1'b0;
		item_ch.operation  = gsu_pkg::OP_NEAREST;
		item_ch.axis       = 1'b0;
		item_ch.coord      = '0;
		item_ch.grid_index = '0;
		result_ch.ready    = 1'b0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_pitch_zero();
		test_basic_grid();
		test_extremes();
		test_random();
		test_backpressure();

		if (mismatch_count == 0 && snap_expect_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
